// ----- rtl/core/lzwd_pkg.sv -----
// shared constants, types and helpers of the lzw decompressor
package lzwd_pkg;

    localparam int TABLE_SIZE           = 4096;
    localparam int STACK_DEPTH_DEF      = 510;
    localparam int BYTES_PER_RESULT_DEF = 8;
    localparam int MAX_RESULTS          = 64;
    localparam int CODE_W               = 12;
    localparam int NEXT_W               = 13;

    localparam logic [CODE_W-1:0] CODE_CLEAR = 12'd256;
    localparam logic [CODE_W-1:0] CODE_END   = 12'd257;
    localparam logic [NEXT_W-1:0] FIRST_FREE = 13'd258;
    localparam logic [NEXT_W-1:0] TABLE_END  = 13'd4096;
    localparam logic [CODE_W-1:0] GROW_10    = 12'd510;
    localparam logic [CODE_W-1:0] GROW_11    = 12'd1022;
    localparam logic [CODE_W-1:0] GROW_12    = 12'd2046;
    localparam logic [3:0]        WIDTH_MIN  = 4'd9;
    localparam logic [31:0]       LIMIT_RESET = 32'hFFFF_FFFF;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_WALK   = 7'b0000100,
        ST_ROOT   = 7'b0001000,
        ST_POP    = 7'b0010000,
        ST_TAIL   = 7'b0100000,
        ST_FLUSH  = 7'b1000000
    } state_t;

    // mask of the low n bits of a byte
    function automatic logic [6:0] low_mask(input logic [2:0] n);
        logic [6:0] m;
        case (n)
            3'd0:    m = 7'h00;
            3'd1:    m = 7'h01;
            3'd2:    m = 7'h03;
            3'd3:    m = 7'h07;
            3'd4:    m = 7'h0F;
            3'd5:    m = 7'h1F;
            3'd6:    m = 7'h3F;
            3'd7:    m = 7'h7F;
            default: m = 7'h00;
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/core/lzwd_if.sv -----
// channel interfaces: compressed input, decoded output, limit write
interface lzwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;
    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface lzwd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        end_of_run;
    logic        stream_done;
    logic        overflow_error;
    modport source (output valid, output out_bytes, output byte_count, output end_of_run,
                    output stream_done, output overflow_error, input ready);
    modport sink   (input valid, input out_bytes, input byte_count, input end_of_run,
                    input stream_done, input overflow_error, output ready);
endinterface

interface lzwd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] output_limit;
    modport source (output valid, output output_limit, input ready);
    modport sink   (input valid, input output_limit, output ready);
endinterface

// ----- rtl/core/lzwd_ram.sv -----
// generic simple dual port ram with registered read
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- rtl/core/lzw_decompressor.sv -----
// lzw decoder top level: bit assembly, table walk, string stack, byte packer
//
//  channel   dir  handshake     payload
//  data_in   in   valid/ready   in_byte[7:0], last_byte
//  data_out  out  valid/ready   out_bytes[63:0], byte_count[3:0], end_of_run,
//                               stream_done, overflow_error
//  cfg       in   valid/ready   output_limit[31:0] (ready always high)
//
// A byte that completes no code goes from idle to flush; a clear, end or ignored
// code passes decode first. A decoded code with L prefix links walks the table
// (one table read per link, one stack read per popped byte); a stack overflow
// ends the walk. A full output word that more bytes follow is pushed before the
// next byte goes in, and the packer waits while data_out stalls a waiting word.
// Reset clears all control state; the tables need no clearing pass.
module lzw_decompressor #(
    parameter int STACK_DEPTH      = lzwd_pkg::STACK_DEPTH_DEF,
    parameter int BYTES_PER_RESULT = lzwd_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lzwd_in_if.sink     data_in,
    lzwd_out_if.source  data_out,
    lzwd_cfg_if.sink    cfg
);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int CW  = $clog2(BYTES_PER_RESULT + 1);
    localparam int CAP = lzwd_pkg::MAX_RESULTS * BYTES_PER_RESULT;
    localparam int SBW = $clog2(CAP + 1);
    localparam int TAW = $clog2(lzwd_pkg::TABLE_SIZE);

    lzwd_pkg::state_t state_reg, state_next;

    logic [11:0] partial_reg, partial_next;
    logic [3:0]  needed_reg, needed_next;
    logic [3:0]  width_reg, width_next;
    logic [12:0] next_free_reg, next_free_next;
    logic [11:0] prev_reg, prev_next;
    logic        have_prev_reg, have_prev_next;
    logic        halted_reg, halted_next;
    logic [31:0] delivered_reg, delivered_next;
    logic [31:0] limit_reg, limit_next;

    logic [11:0] code_reg, code_next;
    logic [2:0]  rem_cnt_reg, rem_cnt_next;
    logic [6:0]  rem_val_reg, rem_val_next;
    logic        code_seen_reg, code_seen_next;
    logic        done_reg, done_next;
    logic        err_reg, err_next;
    logic        known_reg, known_next;
    logic        upd_reg, upd_next;
    logic [7:0]  root_reg, root_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic [SBW-1:0] step_reg, step_next;

    logic [7:0]    word_reg [BYTES_PER_RESULT];
    logic [7:0]    word_next [BYTES_PER_RESULT];
    logic [CW-1:0] cnt_reg, cnt_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_word_reg, out_word_next;
    logic [3:0]  out_cnt_reg, out_cnt_next;
    logic        out_eor_reg, out_eor_next;
    logic        out_done_reg, out_done_next;
    logic        out_err_reg, out_err_next;

    // ram ports
    logic           tbl_wr_en, tbl_rd_en;
    logic [TAW-1:0] tbl_wr_addr, tbl_rd_addr;
    logic [11:0]    prefix_q;
    logic [7:0]     suffix_q;
    logic           stk_wr_en, stk_rd_en;
    logic [SAW-1:0] stk_wr_addr, stk_rd_addr;
    logic [7:0]     stk_q;

    // helpers
    logic        slot_free;
    logic        emit_req, emit_done;
    logic [7:0]  emit_byte;
    logic        push;
    logic [63:0] push_word;
    logic        push_eor, push_err;
    logic [19:0] cat;
    logic [3:0]  shr;
    logic [11:0] walk_c;
    logic [DW-1:0] depth_inc;
    logic [DW-1:0] depth_dec;
    logic        need_out;

    lzwd_ram #(.WIDTH(12), .DEPTH(lzwd_pkg::TABLE_SIZE)) u_prefix (
        .clk(clk), .wr_en(tbl_wr_en), .wr_addr(tbl_wr_addr), .wr_data(prev_reg),
        .rd_en(tbl_rd_en), .rd_addr(tbl_rd_addr), .rd_data(prefix_q)
    );
    lzwd_ram #(.WIDTH(8), .DEPTH(lzwd_pkg::TABLE_SIZE)) u_suffix (
        .clk(clk), .wr_en(tbl_wr_en), .wr_addr(tbl_wr_addr), .wr_data(root_reg),
        .rd_en(tbl_rd_en), .rd_addr(tbl_rd_addr), .rd_data(suffix_q)
    );
    lzwd_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .wr_en(stk_wr_en), .wr_addr(stk_wr_addr), .wr_data(suffix_q),
        .rd_en(stk_rd_en), .rd_addr(stk_rd_addr), .rd_data(stk_q)
    );

    // handshakes and output payload
    assign data_in.ready           = (state_reg == lzwd_pkg::ST_IDLE);
    assign cfg.ready               = 1'b1;
    assign data_out.valid          = out_valid_reg;
    assign data_out.out_bytes      = out_word_reg;
    assign data_out.byte_count     = out_cnt_reg;
    assign data_out.end_of_run     = out_eor_reg;
    assign data_out.stream_done    = out_done_reg;
    assign data_out.overflow_error = out_err_reg;

    assign slot_free = !out_valid_reg || data_out.ready;
    assign emit_req  = (state_reg == lzwd_pkg::ST_ROOT) || (state_reg == lzwd_pkg::ST_POP)
                     || ((state_reg == lzwd_pkg::ST_TAIL) && !known_reg);
    assign emit_byte = (state_reg == lzwd_pkg::ST_POP) ? stk_q : root_reg;
    assign cat       = {partial_reg, data_in.in_byte};
    assign shr       = 4'd8 - needed_reg;
    assign walk_c    = (code_reg < next_free_reg[11:0] || next_free_reg == lzwd_pkg::TABLE_END)
                     ? code_reg : prev_reg;
    assign depth_inc = depth_reg + DW'(1);
    assign depth_dec = depth_reg - DW'(1);
    assign need_out  = (cnt_reg != '0) || done_reg || err_reg;

    // packed word of the packer, upper lanes zero
    always_comb
    begin
        push_word = '0;
        for (int i = 0; i < BYTES_PER_RESULT; i++)
        begin
            push_word[8*i +: 8] = word_reg[i];
        end
    end

    // sequencer, byte emitter and packer
    always_comb
    begin
        state_next     = state_reg;
        partial_next   = partial_reg;
        needed_next    = needed_reg;
        width_next     = width_reg;
        next_free_next = next_free_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        halted_next    = halted_reg;
        delivered_next = delivered_reg;
        limit_next     = cfg.valid ? cfg.output_limit : limit_reg;
        code_next      = code_reg;
        rem_cnt_next   = rem_cnt_reg;
        rem_val_next   = rem_val_reg;
        code_seen_next = code_seen_reg;
        done_next      = done_reg;
        err_next       = err_reg;
        known_next     = known_reg;
        upd_next       = upd_reg;
        root_next      = root_reg;
        depth_next     = depth_reg;
        step_next      = step_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = next_free_reg[TAW-1:0];
        tbl_rd_en      = 1'b0;
        tbl_rd_addr    = walk_c;
        stk_wr_en      = 1'b0;
        stk_wr_addr    = depth_reg[SAW-1:0];
        stk_rd_en      = 1'b0;
        stk_rd_addr    = depth_dec[SAW-1:0];
        push           = 1'b0;
        push_eor       = 1'b0;
        push_err       = 1'b0;
        emit_done      = 1'b0;

        // one decoded byte: limit, result cap, then a packer lane, or a push of the full word
        if (emit_req)
        begin
            if (delivered_reg >= limit_reg)
            begin
                emit_done = 1'b1;
            end
            else if (step_reg >= SBW'(CAP))
            begin
                delivered_next = delivered_reg + 32'd1;
                emit_done      = 1'b1;
            end
            else if (cnt_reg < CW'(BYTES_PER_RESULT))
            begin
                for (int i = 0; i < BYTES_PER_RESULT; i++)
                begin
                    if (cnt_reg == CW'(i))
                    begin
                        word_next[i] = emit_byte;
                    end
                end
                cnt_next       = cnt_reg + CW'(1);
                delivered_next = delivered_reg + 32'd1;
                step_next      = step_reg + SBW'(1);
                emit_done      = 1'b1;
            end
            else if (slot_free)
            begin
                push = 1'b1;
                for (int i = 0; i < BYTES_PER_RESULT; i++)
                begin
                    word_next[i] = 8'd0;
                end
                cnt_next = '0;
            end
        end

        case (state_reg)
            lzwd_pkg::ST_IDLE:
            begin
                if (data_in.valid)
                begin
                    done_next      = data_in.last_byte;
                    err_next       = 1'b0;
                    step_next      = '0;
                    code_seen_next = 1'b0;
                    if (halted_reg)
                    begin
                        state_next = lzwd_pkg::ST_FLUSH;
                    end
                    else if (needed_reg <= 4'd8)
                    begin
                        code_next      = 12'(cat >> shr);
                        rem_cnt_next   = shr[2:0];
                        rem_val_next   = data_in.in_byte[6:0] & lzwd_pkg::low_mask(shr[2:0]);
                        code_seen_next = 1'b1;
                        state_next     = lzwd_pkg::ST_DECODE;
                    end
                    else
                    begin
                        partial_next = cat[11:0];
                        needed_next  = needed_reg - 4'd8;
                        state_next   = lzwd_pkg::ST_FLUSH;
                    end
                end
            end

            lzwd_pkg::ST_DECODE:
            begin
                known_next = 1'b1;
                upd_next   = 1'b0;
                depth_next = '0;
                if (code_reg == lzwd_pkg::CODE_CLEAR)
                begin
                    width_next     = lzwd_pkg::WIDTH_MIN;
                    next_free_next = lzwd_pkg::FIRST_FREE;
                    have_prev_next = 1'b0;
                    prev_next      = '0;
                    state_next     = lzwd_pkg::ST_FLUSH;
                end
                else if (code_reg == lzwd_pkg::CODE_END)
                begin
                    done_next  = 1'b1;
                    state_next = lzwd_pkg::ST_FLUSH;
                end
                else if (!have_prev_reg)
                begin
                    if (code_reg < lzwd_pkg::CODE_CLEAR)
                    begin
                        root_next      = code_reg[7:0];
                        prev_next      = code_reg;
                        have_prev_next = 1'b1;
                        state_next     = lzwd_pkg::ST_ROOT;
                    end
                    else
                    begin
                        state_next = lzwd_pkg::ST_FLUSH;
                    end
                end
                else
                begin
                    known_next = ({1'b0, code_reg} < next_free_reg);
                    upd_next   = 1'b1;
                    root_next  = walk_c[7:0];
                    if ({1'b0, walk_c} >= lzwd_pkg::FIRST_FREE)
                    begin
                        tbl_rd_en  = 1'b1;
                        state_next = lzwd_pkg::ST_WALK;
                    end
                    else
                    begin
                        state_next = lzwd_pkg::ST_ROOT;
                    end
                end
            end

            // push this link's suffix, follow its prefix
            lzwd_pkg::ST_WALK:
            begin
                stk_wr_en   = 1'b1;
                depth_next  = depth_inc;
                tbl_rd_addr = prefix_q;
                root_next   = prefix_q[7:0];
                if ({1'b0, prefix_q} >= lzwd_pkg::FIRST_FREE)
                begin
                    if (depth_inc >= DW'(STACK_DEPTH))
                    begin
                        err_next   = 1'b1;
                        state_next = lzwd_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        tbl_rd_en = 1'b1;
                    end
                end
                else
                begin
                    state_next = lzwd_pkg::ST_ROOT;
                end
            end

            lzwd_pkg::ST_ROOT, lzwd_pkg::ST_POP:
            begin
                if (emit_done)
                begin
                    if (depth_reg != '0)
                    begin
                        stk_rd_en  = 1'b1;
                        depth_next = depth_dec;
                        state_next = lzwd_pkg::ST_POP;
                    end
                    else
                    begin
                        state_next = lzwd_pkg::ST_TAIL;
                    end
                end
            end

            // repeated root for an unknown code, then the new table entry
            lzwd_pkg::ST_TAIL:
            begin
                if (known_reg || emit_done)
                begin
                    if (upd_reg && next_free_reg < lzwd_pkg::TABLE_END)
                    begin
                        tbl_wr_en      = 1'b1;
                        next_free_next = next_free_reg + 13'd1;
                        prev_next      = known_reg ? code_reg : next_free_reg[11:0];
                        if (next_free_reg[11:0] == lzwd_pkg::GROW_10)
                        begin
                            width_next = 4'd10;
                        end
                        else if (next_free_reg[11:0] == lzwd_pkg::GROW_11)
                        begin
                            width_next = 4'd11;
                        end
                        else if (next_free_reg[11:0] == lzwd_pkg::GROW_12)
                        begin
                            width_next = 4'd12;
                        end
                    end
                    else if (upd_reg)
                    begin
                        prev_next = code_reg;
                    end
                    state_next = lzwd_pkg::ST_FLUSH;
                end
            end

            // closing beat of the item, then stream bookkeeping
            lzwd_pkg::ST_FLUSH:
            begin
                if (!need_out || slot_free)
                begin
                    push     = need_out;
                    push_eor = 1'b1;
                    push_err = err_reg;
                    for (int i = 0; i < BYTES_PER_RESULT; i++)
                    begin
                        word_next[i] = 8'd0;
                    end
                    cnt_next   = '0;
                    state_next = lzwd_pkg::ST_IDLE;
                    if (err_reg)
                    begin
                        halted_next = 1'b1;
                    end
                    if (done_reg)
                    begin
                        partial_next   = '0;
                        needed_next    = lzwd_pkg::WIDTH_MIN;
                        width_next     = lzwd_pkg::WIDTH_MIN;
                        next_free_next = lzwd_pkg::FIRST_FREE;
                        have_prev_next = 1'b0;
                        prev_next      = '0;
                        delivered_next = '0;
                        halted_next    = 1'b0;
                    end
                    else if (code_seen_reg)
                    begin
                        partial_next = {5'd0, rem_val_reg};
                        needed_next  = width_reg - {1'b0, rem_cnt_reg};
                    end
                end
            end

            default:
            begin
                state_next = lzwd_pkg::ST_IDLE;
            end
        endcase

        // output register
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_cnt_next   = out_cnt_reg;
        out_eor_next   = out_eor_reg;
        out_done_next  = out_done_reg;
        out_err_next   = out_err_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_word_next  = push_word;
            out_cnt_next   = 4'(cnt_reg);
            out_eor_next   = push_eor;
            out_done_next  = done_reg;
            out_err_next   = push_err;
        end
        else if (data_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzwd_pkg::ST_IDLE;
            partial_reg   <= '0;
            needed_reg    <= lzwd_pkg::WIDTH_MIN;
            width_reg     <= lzwd_pkg::WIDTH_MIN;
            next_free_reg <= lzwd_pkg::FIRST_FREE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            halted_reg    <= 1'b0;
            delivered_reg <= '0;
            limit_reg     <= lzwd_pkg::LIMIT_RESET;
            done_reg      <= 1'b0;
            err_reg       <= 1'b0;
            code_seen_reg <= 1'b0;
            depth_reg     <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BYTES_PER_RESULT; i++)
            begin
                word_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            partial_reg   <= partial_next;
            needed_reg    <= needed_next;
            width_reg     <= width_next;
            next_free_reg <= next_free_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            halted_reg    <= halted_next;
            delivered_reg <= delivered_next;
            limit_reg     <= limit_next;
            done_reg      <= done_next;
            err_reg       <= err_next;
            code_seen_reg <= code_seen_next;
            depth_reg     <= depth_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            word_reg      <= word_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        rem_cnt_reg  <= rem_cnt_next;
        rem_val_reg  <= rem_val_next;
        known_reg    <= known_next;
        upd_reg      <= upd_next;
        root_reg     <= root_next;
        out_word_reg <= out_word_next;
        out_cnt_reg  <= out_cnt_next;
        out_eor_reg  <= out_eor_next;
        out_done_reg <= out_done_next;
        out_err_reg  <= out_err_next;
    end

    // stack never deeper than its memory
    assert property (@(posedge clk) disable iff (!rst_n) depth_reg <= DW'(STACK_DEPTH))
        else $error("string stack depth out of range");

    // packer never holds more than one result's bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(BYTES_PER_RESULT))
        else $error("packer count out of range");

    // previous code always refers to an existing entry
    assert property (@(posedge clk) disable iff (!rst_n)
        have_prev_reg |-> ({1'b0, prev_reg} < next_free_reg))
        else $error("previous code beyond table fill");

    // code width stays between 9 and 12 bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (width_reg >= lzwd_pkg::WIDTH_MIN) && (width_reg <= 4'd12))
        else $error("code width out of range");

    // a halted stream produces no table walk
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (state_reg != lzwd_pkg::ST_WALK))
        else $error("table walk while halted");
endmodule
